>>> hdl/b2r_pkg.sv
// Shared types, constants and digit spelling table for the Roman numeral encoder.
package b2r_pkg;

    localparam int VALUE_W   = 13;
    localparam int LETTER_W  = 7;
    localparam int MODE_W    = 3;
    localparam int DIGIT_W   = 4;
    localparam int SPELL_MAX = 5;
    localparam int IDX_W     = $clog2(SPELL_MAX);
    localparam int NUM_POS   = 4;
    localparam int POS_W     = $clog2(NUM_POS);

    localparam int MAX_VALUE = 4999;
    localparam int RECIP_W   = 16;
    localparam int RECIP_10  = 52429;
    localparam int RECIP_SH  = 19;
    localparam int PROD_W    = VALUE_W + RECIP_W;

    localparam int MODE_CLOCK  = 0;
    localparam int MODE_MIDDLE = 1;
    localparam int MODE_MEDIEVAL = 2;

    localparam logic [LETTER_W-1:0] CH_NUL = 7'h00;
    localparam logic [LETTER_W-1:0] CH_I   = 7'h49;
    localparam logic [LETTER_W-1:0] CH_V   = 7'h56;
    localparam logic [LETTER_W-1:0] CH_X   = 7'h58;
    localparam logic [LETTER_W-1:0] CH_L   = 7'h4C;
    localparam logic [LETTER_W-1:0] CH_C   = 7'h43;
    localparam logic [LETTER_W-1:0] CH_D   = 7'h44;
    localparam logic [LETTER_W-1:0] CH_M   = 7'h4D;
    localparam logic [LETTER_W-1:0] CH_A   = 7'h41;
    localparam logic [LETTER_W-1:0] CH_S   = 7'h53;
    localparam logic [LETTER_W-1:0] CH_N   = 7'h4E;
    localparam logic [LETTER_W-1:0] CH_Q   = 7'h51;
    localparam logic [LETTER_W-1:0] CH_W   = 7'h57;
    localparam logic [LETTER_W-1:0] CH_Z   = 7'h5A;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_TOO_LARGE = 2'd1,
        ST_ZERO      = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_SPLIT,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic capture;
        logic load_single;
        logic split;
        logic emit;
    } t_ctl_cmd;

    typedef struct packed {
        logic special;
        logic split_last;
        logic slot_free;
        logic last_beat;
    } t_dp_sts;

    typedef struct packed {
        logic [IDX_W-1:0]                   len;
        logic [SPELL_MAX-1:0][LETTER_W-1:0] ltr;
    } t_spell;

    function automatic t_spell spell_digit(
        input logic [POS_W-1:0]   pos,
        input logic [DIGIT_W-1:0] d,
        input logic [MODE_W-1:0]  mode
    );
        t_spell              s;
        logic [LETTER_W-1:0] u;
        logic [LETTER_W-1:0] f;
        logic [LETTER_W-1:0] t;
        logic                hit;
        s   = '0;
        hit = 1'b0;
        unique case (pos)
            2'd0: begin
                u = CH_I; f = CH_V; t = CH_X;
            end
            2'd1: begin
                u = CH_X; f = CH_L; t = CH_C;
            end
            2'd2: begin
                u = CH_C; f = CH_D; t = CH_M;
            end
            default: begin
                u = CH_M; f = CH_M; t = CH_M;
            end
        endcase

        if (mode[MODE_CLOCK] && pos == 2'd0 && d == 4'd4) begin
            s.len = 3'd4;
            s.ltr[0] = CH_I; s.ltr[1] = CH_I; s.ltr[2] = CH_I; s.ltr[3] = CH_I;
            hit = 1'b1;
        end else if (mode[MODE_MIDDLE]) begin
            if (pos == 2'd0 && d == 4'd5) begin
                s.len = 3'd5;
                s.ltr[0] = CH_I; s.ltr[1] = CH_I; s.ltr[2] = CH_I;
                s.ltr[3] = CH_I; s.ltr[4] = CH_I;
                hit = 1'b1;
            end else if (pos == 2'd0 && d == 4'd8) begin
                s.len = 3'd3;
                s.ltr[0] = CH_I; s.ltr[1] = CH_I; s.ltr[2] = CH_X;
                hit = 1'b1;
            end else if (pos == 2'd1 && d == 4'd1) begin
                s.len = 3'd2;
                s.ltr[0] = CH_V; s.ltr[1] = CH_V;
                hit = 1'b1;
            end
        end else if (mode[MODE_MEDIEVAL]) begin
            hit   = 1'b1;
            s.len = 3'd1;
            if (pos == 2'd0 && d == 4'd5) begin
                s.ltr[0] = CH_A;
            end else if (pos == 2'd1 && d == 4'd7) begin
                s.ltr[0] = CH_S;
            end else if (pos == 2'd1 && d == 4'd9) begin
                s.ltr[0] = CH_N;
            end else if (pos == 2'd2 && d == 4'd5) begin
                s.ltr[0] = CH_Q;
            end else if (pos == 2'd2 && d == 4'd8) begin
                s.ltr[0] = CH_W;
            end else if (pos == 2'd3 && d == 4'd2) begin
                s.ltr[0] = CH_Z;
            end else begin
                hit   = 1'b0;
                s.len = '0;
            end
        end

        if (!hit) begin
            if (pos == 2'd3) begin
                s.len = (d > 4'd4) ? 3'd4 : d[IDX_W-1:0];
                for (int k = 0; k < 4; k++) begin
                    if (4'(k) < d) begin
                        s.ltr[k] = CH_M;
                    end
                end
            end else begin
                unique case (d)
                    4'd1: begin
                        s.len = 3'd1; s.ltr[0] = u;
                    end
                    4'd2: begin
                        s.len = 3'd2; s.ltr[0] = u; s.ltr[1] = u;
                    end
                    4'd3: begin
                        s.len = 3'd3; s.ltr[0] = u; s.ltr[1] = u; s.ltr[2] = u;
                    end
                    4'd4: begin
                        s.len = 3'd2; s.ltr[0] = u; s.ltr[1] = f;
                    end
                    4'd5: begin
                        s.len = 3'd1; s.ltr[0] = f;
                    end
                    4'd6: begin
                        s.len = 3'd2; s.ltr[0] = f; s.ltr[1] = u;
                    end
                    4'd7: begin
                        s.len = 3'd3; s.ltr[0] = f; s.ltr[1] = u; s.ltr[2] = u;
                    end
                    4'd8: begin
                        s.len = 3'd4; s.ltr[0] = f; s.ltr[1] = u;
                        s.ltr[2] = u; s.ltr[3] = u;
                    end
                    4'd9: begin
                        s.len = 3'd2; s.ltr[0] = u; s.ltr[1] = t;
                    end
                    default: begin
                        s.len = '0;
                    end
                endcase
            end
        end
        return s;
    endfunction

endpackage

>>> hdl/b2r_ctrl.sv
// Sequencing state machine: accept, range check, digit split, letter emission.
module b2r_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  b2r_pkg::t_dp_sts  i_sts,
    output b2r_pkg::t_ctl_cmd o_cmd
);
    import b2r_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.special) begin
                    if (i_sts.slot_free) begin
                        o_cmd.load_single = 1'b1;
                        n_state           = S_IDLE;
                    end
                end else begin
                    n_state = S_SPLIT;
                end
            end
            S_SPLIT: begin
                o_cmd.split = 1'b1;
                if (i_sts.split_last) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_sts.slot_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_sts.last_beat) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

>>> hdl/b2r_dpath.sv
// Datapath: mode register, digit split by reciprocal multiply, spelling and output register.
module b2r_dpath (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    input  logic [b2r_pkg::MODE_W-1:0]       i_cfg_mode_flags,
    input  logic [b2r_pkg::VALUE_W-1:0]      i_value,
    input  b2r_pkg::t_ctl_cmd                i_cmd,
    output b2r_pkg::t_dp_sts                 o_sts,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [b2r_pkg::LETTER_W-1:0]     o_letter,
    output logic                             o_last,
    output logic [1:0]                       o_status
);
    import b2r_pkg::*;

    logic [MODE_W-1:0]               r_mode;
    logic [VALUE_W-1:0]              r_rem;
    logic [NUM_POS-1:0][DIGIT_W-1:0] r_dig;
    logic [POS_W-1:0]                r_pos;
    logic [IDX_W-1:0]                r_idx;
    logic                            r_out_valid;
    logic [LETTER_W-1:0]             r_letter;
    logic                            r_last;
    logic [1:0]                      r_status;

    logic [PROD_W-1:0]               w_prod;
    logic [VALUE_W-1:0]              w_quot;
    logic [VALUE_W-1:0]              w_quot10;
    logic [DIGIT_W-1:0]              w_digit;
    t_spell                          w_spell;
    logic                            w_lower_zero;
    logic                            w_end_digit;
    logic                            w_too_large;
    logic                            w_zero;
    logic                            w_slot_free;

    assign w_prod      = PROD_W'(r_rem) * PROD_W'(RECIP_10);
    assign w_quot      = VALUE_W'(w_prod >> RECIP_SH);
    assign w_quot10    = (w_quot << 3) + (w_quot << 1);
    assign w_digit     = DIGIT_W'(r_rem - w_quot10);

    assign w_spell     = spell_digit(r_pos, r_dig[r_pos], r_mode);
    assign w_end_digit = (w_spell.len == '0) || (r_idx == w_spell.len - 3'd1);

    always_comb begin
        unique case (r_pos)
            2'd3:    w_lower_zero = (r_dig[2] == '0) && (r_dig[1] == '0) && (r_dig[0] == '0);
            2'd2:    w_lower_zero = (r_dig[1] == '0) && (r_dig[0] == '0);
            2'd1:    w_lower_zero = (r_dig[0] == '0);
            default: w_lower_zero = 1'b1;
        endcase
    end

    assign w_too_large = (r_rem > VALUE_W'(MAX_VALUE));
    assign w_zero      = (r_rem == '0);
    assign w_slot_free = !r_out_valid || i_ready;

    assign o_sts.special    = w_too_large || w_zero;
    assign o_sts.split_last = (r_pos == 2'd2);
    assign o_sts.slot_free  = w_slot_free;
    assign o_sts.last_beat  = (w_spell.len != '0) && w_end_digit && w_lower_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= '0;
        end else if (i_cfg_valid) begin
            r_mode <= i_cfg_mode_flags;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_idx <= '0;
        end else if (i_cmd.capture) begin
            r_rem <= i_value;
            r_pos <= '0;
            r_idx <= '0;
        end else if (i_cmd.split) begin
            r_dig[r_pos] <= w_digit;
            r_rem        <= w_quot;
            r_pos        <= r_pos + 2'd1;
            if (r_pos == 2'd2) begin
                r_dig[3] <= w_quot[DIGIT_W-1:0];
            end
        end else if (i_cmd.emit) begin
            if (w_end_digit) begin
                r_idx <= '0;
                r_pos <= r_pos - 2'd1;
            end else begin
                r_idx <= r_idx + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_single || (i_cmd.emit && w_spell.len != '0)) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_single) begin
            r_last <= 1'b1;
            if (w_too_large) begin
                r_letter <= CH_NUL;
                r_status <= ST_TOO_LARGE;
            end else if (r_mode[MODE_MIDDLE]) begin
                r_letter <= CH_N;
                r_status <= ST_OK;
            end else begin
                r_letter <= CH_NUL;
                r_status <= ST_ZERO;
            end
        end else if (i_cmd.emit && w_spell.len != '0) begin
            r_letter <= w_spell.ltr[r_idx];
            r_last   <= w_end_digit && w_lower_zero;
            r_status <= ST_OK;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_letter = r_letter;
    assign o_last   = r_last;
    assign o_status = r_status;

endmodule

>>> hdl/binary_to_roman_numeral_encoder_unit.sv
// A value is range checked and split into digits before emission; leading zeros delay it.
// Throughput: one letter beat per cycle unless the output stalls; a zero digit ahead of the
// last letter takes an emission step without a letter. The next input beat is taken once the
// final letter is loaded.
// Reset is synchronous, active low: clears the sequencer, output valid and the mode register.
module binary_to_roman_numeral_encoder_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [b2r_pkg::VALUE_W-1:0]  i_value,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [b2r_pkg::LETTER_W-1:0] o_letter,
    output logic                         o_last,
    output logic [1:0]                   o_status,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [b2r_pkg::MODE_W-1:0]   i_cfg_mode_flags
);
    import b2r_pkg::*;

    t_ctl_cmd w_cmd;
    t_dp_sts  w_sts;

    assign o_cfg_ready = 1'b1;

    b2r_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    b2r_dpath u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_mode_flags (i_cfg_mode_flags),
        .i_value          (i_value),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_letter         (o_letter),
        .o_last           (o_last),
        .o_status         (o_status)
    );

endmodule

>>> sim/binary_to_roman_numeral_encoder_unit_tb.sv
// Testbench for the Roman numeral encoder: random and directed values, modes and flow gaps.
`timescale 1ns / 1ps

module binary_to_roman_numeral_encoder_unit_tb;
    import b2r_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int LETTER_CAP  = 17;
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 29;
    localparam int DIR_ITEMS   = 24;
    localparam int DRAIN_WAIT  = 30;

    typedef struct packed {
        logic [LETTER_W-1:0] letter;
        logic                last;
        t_status             status;
    } t_letter_beat;

    class numeral_checker;
        t_letter_beat        letters_due[$];
        logic [LETTER_W-1:0] spelled[$];
        int                  mismatches;

        function new();
            mismatches = 0;
        endfunction

        task report_mismatch(input string what);
            $display("[%0t] mismatch: %s", $realtime, what);
            mismatches++;
        endtask

        function void owe(input logic [LETTER_W-1:0] c, input logic last, input t_status st);
            t_letter_beat b;
            b.letter = c;
            b.last   = last;
            b.status = st;
            letters_due.push_back(b);
        endfunction

        function void add(input logic [LETTER_W-1:0] c);
            if (spelled.size() < LETTER_CAP) begin
                spelled.push_back(c);
            end
        endfunction

        function void spell_place(input int pos, input int d, input logic [MODE_W-1:0] mode);
            logic [LETTER_W-1:0] one;
            logic [LETTER_W-1:0] five;
            logic [LETTER_W-1:0] ten;
            case (pos)
                0: begin
                    one = CH_I; five = CH_V; ten = CH_X;
                end
                1: begin
                    one = CH_X; five = CH_L; ten = CH_C;
                end
                default: begin
                    one = CH_C; five = CH_D; ten = CH_M;
                end
            endcase
            if (mode[MODE_CLOCK] && pos == 0 && d == 4) begin
                repeat (4) add(CH_I);
                return;
            end
            if (mode[MODE_MIDDLE]) begin
                if (pos == 0 && d == 5) begin
                    repeat (5) add(CH_I);
                    return;
                end
                if (pos == 0 && d == 8) begin
                    add(CH_I); add(CH_I); add(CH_X);
                    return;
                end
                if (pos == 1 && d == 1) begin
                    add(CH_V); add(CH_V);
                    return;
                end
            end else if (mode[MODE_MEDIEVAL]) begin
                if (pos == 0 && d == 5) begin
                    add(CH_A); return;
                end
                if (pos == 1 && d == 7) begin
                    add(CH_S); return;
                end
                if (pos == 1 && d == 9) begin
                    add(CH_N); return;
                end
                if (pos == 2 && d == 5) begin
                    add(CH_Q); return;
                end
                if (pos == 2 && d == 8) begin
                    add(CH_W); return;
                end
                if (pos == 3 && d == 2) begin
                    add(CH_Z); return;
                end
            end
            if (pos == 3) begin
                repeat (d) add(CH_M);
                return;
            end
            case (d)
                1, 2, 3: begin
                    repeat (d) add(one);
                end
                4: begin
                    add(one); add(five);
                end
                5, 6, 7, 8: begin
                    add(five);
                    repeat (d - 5) add(one);
                end
                9: begin
                    add(one); add(ten);
                end
                default: begin
                end
            endcase
        endfunction

        function void take_value(input logic [VALUE_W-1:0] v, input logic [MODE_W-1:0] mode);
            int n;
            n = int'(v);
            if (n > MAX_VALUE) begin
                owe(CH_NUL, 1'b1, ST_TOO_LARGE);
                return;
            end
            if (n == 0) begin
                if (mode[MODE_MIDDLE]) begin
                    owe(CH_N, 1'b1, ST_OK);
                end else begin
                    owe(CH_NUL, 1'b1, ST_ZERO);
                end
                return;
            end
            spelled.delete();
            spell_place(3, n / 1000, mode);
            spell_place(2, (n / 100) % 10, mode);
            spell_place(1, (n / 10) % 10, mode);
            spell_place(0, n % 10, mode);
            foreach (spelled[k]) begin
                owe(spelled[k], k == spelled.size() - 1, ST_OK);
            end
        endfunction

        task check_letter(input logic [LETTER_W-1:0] c, input logic last, input logic [1:0] st);
            t_letter_beat want;
            if (letters_due.size() == 0) begin
                report_mismatch($sformatf("letter beat 0x%0h with nothing due", c));
                return;
            end
            want = letters_due.pop_front();
            if (c !== want.letter) begin
                report_mismatch($sformatf("letter 0x%0h, want 0x%0h", c, want.letter));
            end
            if (last !== want.last) begin
                report_mismatch($sformatf("last %b, want %b", last, want.last));
            end
            if (st !== want.status) begin
                report_mismatch($sformatf("status %0d, want %0d", st, want.status));
            end
        endtask

        task flag_leftovers();
            if (letters_due.size() != 0) begin
                report_mismatch($sformatf("%0d letter beats never arrived", letters_due.size()));
            end
        endtask
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_ready;
    logic [VALUE_W-1:0]  i_value;
    logic                o_valid;
    logic                i_ready;
    logic [LETTER_W-1:0] o_letter;
    logic                o_last;
    logic [1:0]          o_status;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [MODE_W-1:0]   i_cfg_mode_flags;

    numeral_checker      board;
    logic [MODE_W-1:0]   mode_now;
    bit                  calm;
    int                  cycle_count;

    int dir_mode [DIR_ITEMS] = '{0, 0, 0, 0, 0, 0, 0, 0, 0,
                                 7, 7, 7, 7, 7,
                                 4, 4, 4, 4,
                                 1, 1,
                                 2, 2, 2, 2};
    int dir_value [DIR_ITEMS] = '{0, 1, 4999, 5000, 8191, 4888, 3999, 1994, 4000,
                                  0, 4885, 14, 18, 10,
                                  2575, 2898, 4585, 15,
                                  4, 4444,
                                  5, 8, 11, 0};
    int phase_mode [PHASES] = '{3, 7, 0, 5, 2, 6, 4, 1, 7, 0};

    binary_to_roman_numeral_encoder_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_value          (i_value),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_letter         (o_letter),
        .o_last           (o_last),
        .o_status         (o_status),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_mode_flags (i_cfg_mode_flags)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("binary_to_roman_numeral_encoder_unit verification failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_ready <= calm || ($urandom_range(99) >= 12);
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_ready === 1'b1) begin
            board.check_letter(o_letter, o_last, o_status);
        end
    end

    function automatic bit take_break();
        return !calm && ($urandom_range(99) < 12);
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value();
        int r;
        r = $urandom_range(99);
        if (r < 6) begin
            return '0;
        end else if (r < 14) begin
            return VALUE_W'($urandom_range(8191, MAX_VALUE + 1));
        end else if (r < 18) begin
            return VALUE_W'($urandom_range(MAX_VALUE + 1, MAX_VALUE));
        end
        return VALUE_W'($urandom_range(MAX_VALUE, 1));
    endfunction

    task automatic send_value(input logic [VALUE_W-1:0] v);
        while (take_break()) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_value <= v;
        @(posedge i_clk);
        while (o_ready !== 1'b1) @(posedge i_clk);
        board.take_value(v, mode_now);
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        while (board.letters_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_mode(input logic [MODE_W-1:0] m);
        i_cfg_valid      <= 1'b1;
        i_cfg_mode_flags <= m;
        @(posedge i_clk);
        while (o_cfg_ready !== 1'b1) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        mode_now = m;
    endtask

    initial begin
        board            = new();
        mode_now         = '0;
        calm             = 1'b0;
        cycle_count      = 0;
        i_rst_n          <= 1'b0;
        i_valid          <= 1'b0;
        i_value          <= '0;
        i_ready          <= 1'b0;
        i_cfg_valid      <= 1'b0;
        i_cfg_mode_flags <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < DIR_ITEMS; i++) begin
            if (i == 0 || dir_mode[i] != dir_mode[i-1]) begin
                settle();
                write_mode(MODE_W'(dir_mode[i]));
            end
            send_value(VALUE_W'(dir_value[i]));
        end

        for (int p = 0; p < PHASES; p++) begin
            settle();
            write_mode(MODE_W'(phase_mode[p]));
            calm = (p == 4);
            for (int j = 0; j < PHASE_ITEMS; j++) begin
                send_value(pick_value());
            end
        end
        calm = 1'b0;

        settle();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        board.flag_leftovers();
        if (board.mismatches == 0) begin
            $display("binary_to_roman_numeral_encoder_unit verification clean");
        end else begin
            $display("binary_to_roman_numeral_encoder_unit verification failed");
        end
        $finish;
    end

endmodule

>>> filelist.f
hdl/b2r_pkg.sv
hdl/b2r_ctrl.sv
hdl/b2r_dpath.sv
hdl/binary_to_roman_numeral_encoder_unit.sv
sim/binary_to_roman_numeral_encoder_unit_tb.sv
